### hw/rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the field widths, operation and status codes, and the controller command word.
// No dependencies.
package dq_pkg;

   localparam int OPCODE_WIDTH   = 3;
   localparam int POSITION_WIDTH = 10;
   localparam int VALUE_WIDTH    = 32;
   localparam int STATUS_WIDTH   = 2;
   localparam int OCC_WIDTH      = 11;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ_AT    = 3'd4,
      OP_WRITE_AT   = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic load_req;
      logic execute;
      logic load_out;
   } dq_cmd_type;

endpackage

### hw/rtl/dq_datapath.sv
// Datapath of the double-ended queue: request registers, ring store, head and count,
// and the result register. Driven by the command word from dq_control.
// Depends on dq_pkg.
module dq_datapath #(
   parameter int CAPACITY   = 1024,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dq_pkg::dq_cmd_type                  cmd,
   input  logic [dq_pkg::OPCODE_WIDTH-1:0]     req_opcode,
   input  logic [dq_pkg::POSITION_WIDTH-1:0]   req_position,
   input  logic [dq_pkg::VALUE_WIDTH-1:0]      req_value,
   output logic [dq_pkg::VALUE_WIDTH-1:0]      rsp_read_value,
   output logic [dq_pkg::STATUS_WIDTH-1:0]     rsp_status,
   output logic [dq_pkg::OCC_WIDTH-1:0]        rsp_occupancy
);
   import dq_pkg::*;

   localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int OFS_W = (CNT_W > POSITION_WIDTH) ? CNT_W : POSITION_WIDTH;
   localparam int SUM_W = OFS_W + 1;

   logic [OPCODE_WIDTH-1:0]   op_ff;
   logic [POSITION_WIDTH-1:0] pos_ff;
   logic [ELEM_WIDTH-1:0]     val_ff;
   logic [PTR_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ELEM_WIDTH-1:0]     mem [CAPACITY];
   logic [ELEM_WIDTH-1:0]     rd_data_ff;
   logic                      rd_sel_ff, rd_sel_in;
   status_type                st_ff, st_in;
   logic [VALUE_WIDTH-1:0]    read_value_ff;
   logic [STATUS_WIDTH-1:0]   status_ff;
   logic [OCC_WIDTH-1:0]      occupancy_ff;

   opcode_type       op;
   logic [OFS_W-1:0] offset;
   logic [SUM_W-1:0] sum;
   logic [PTR_W-1:0] slot, head_dec, head_inc, addr;
   logic             full, empty, pos_ok, we, exec_ok;
   logic [63:0]      val_wide, rd_wide;

   assign op       = opcode_type'(op_ff);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign pos_ok   = (32'(pos_ff) < 32'(count_ff));
   assign head_dec = (head_ff == '0) ? PTR_W'(CAPACITY - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == PTR_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
   assign val_wide = 64'(req_value);
   assign rd_wide  = 64'(rd_data_ff);

   always_comb begin
      unique case (op) inside
         OP_PUSH_BACK:            offset = OFS_W'(count_ff);
         OP_POP_BACK:             offset = OFS_W'(count_ff - 1'b1);
         OP_READ_AT, OP_WRITE_AT: offset = OFS_W'(pos_ff);
         default:                 offset = '0;
      endcase
   end

   assign sum  = SUM_W'(head_ff) + SUM_W'(offset);
   assign slot = (sum >= SUM_W'(CAPACITY)) ? PTR_W'(sum - SUM_W'(CAPACITY)) : PTR_W'(sum);

   always_comb begin
      we        = 1'b0;
      rd_sel_in = 1'b0;
      st_in     = ST_OK;
      addr      = slot;
      head_in   = head_ff;
      count_in  = count_ff;
      unique case (op)
         OP_PUSH_FRONT: begin
            addr = head_dec;
            if (full) begin
               st_in = ST_FULL;
            end else begin
               we       = 1'b1;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               st_in = ST_FULL;
            end else begin
               we       = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               st_in = ST_EMPTY;
            end else begin
               rd_sel_in = 1'b1;
               head_in   = head_inc;
               count_in  = count_ff - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               st_in = ST_EMPTY;
            end else begin
               rd_sel_in = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         OP_READ_AT: begin
            if (!pos_ok) begin
               st_in = ST_EMPTY;
            end else begin
               rd_sel_in = 1'b1;
            end
         end
         OP_WRITE_AT: begin
            if (!pos_ok) begin
               st_in = ST_EMPTY;
            end else begin
               we = 1'b1;
            end
         end
         default: begin
            st_in = ST_EMPTY;
         end
      endcase
   end

   assign exec_ok = (st_in == ST_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_opcode;
         pos_ff <= req_position;
         val_ff <= val_wide[ELEM_WIDTH-1:0];
      end
      if (cmd.execute) begin
         rd_sel_ff <= rd_sel_in;
         st_ff     <= st_in;
      end
      if (cmd.load_out) begin
         read_value_ff <= rd_sel_ff ? rd_wide[VALUE_WIDTH-1:0] : '0;
         status_ff     <= st_ff;
         occupancy_ff  <= OCC_WIDTH'(32'(count_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (we) begin
            mem[addr] <= val_ff;
         end
         rd_data_ff <= mem[addr];
      end
   end

   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_occupancy  = occupancy_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("element count beyond capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < CAPACITY)
      else $error("head pointer outside ring");

   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && !exec_ok |=> $stable(count_ff) && $stable(head_ff))
      else $error("failed operation changed queue state");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.execute |=> $stable(count_ff) && $stable(head_ff))
      else $error("queue state changed outside execute");

endmodule

### hw/rtl/dq_control.sv
// Controller of the double-ended queue: sequences capture, store access and result load,
// and owns the request and result handshakes.
// Depends on dq_pkg.
module dq_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dq_pkg::dq_cmd_type cmd
);
   import dq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACCESS,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign cmd.load_req = (state_ff == S_IDLE) && req_valid;
   assign cmd.execute  = (state_ff == S_ACCESS);
   assign cmd.load_out = (state_ff == S_FINISH) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_ACCESS;
               end
            end
            S_ACCESS: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_access_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACCESS |=> state_ff == S_FINISH)
      else $error("access not followed by finish");

   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && req_valid |=> state_ff == S_ACCESS)
      else $error("accepted word not taken into access");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("result raised outside finish");

endmodule

### hw/rtl/double_ended_queue.sv
// Double-ended queue on a ring store with head pointer and element count.
// Each request word passes through the controller sequence: capture, access with
// registered read, then result load; a new word is captured only after the last one
// is loaded into the result register, and a stalled result lets one more word
// be captured, which then holds in result load until the output frees.
// Reset clears head, count and handshake state at once; the store is not cleared.
module double_ended_queue #(
   parameter int CAPACITY   = 1024,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dq_pkg::OPCODE_WIDTH-1:0]     req_opcode,
   input  logic [dq_pkg::POSITION_WIDTH-1:0]   req_position,
   input  logic [dq_pkg::VALUE_WIDTH-1:0]      req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dq_pkg::VALUE_WIDTH-1:0]      rsp_read_value,
   output logic [dq_pkg::STATUS_WIDTH-1:0]     rsp_status,
   output logic [dq_pkg::OCC_WIDTH-1:0]        rsp_occupancy
);
   import dq_pkg::*;

   dq_cmd_type cmd;

   dq_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dq_datapath #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

endmodule
